// ===== rtl/fthr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and binary16 field helpers for the half-precision tanh unit.
package fthr_pkg;

	localparam int LANES   = 4;
	localparam int FP_W    = 16;
	localparam int TDATA_W = ((LANES * FP_W + LANES + 7) / 8) * 8;

	// Fixed-point magnitude used inside the arithmetic: the LSB weighs 2^-48 and the
	// top bit weighs 2^3. The clamp keeps every intermediate value below 16.
	localparam int FIX_W   = 52;
	localparam int SH_W    = 6;
	localparam int SUB_SH  = 24;

	localparam int FMA_LAT   = 4;
	localparam int DIV_STEPS = 14;
	localparam int DIV_LAT   = DIV_STEPS + 4;
	localparam int LANE_LAT  = 5 * FMA_LAT + DIV_LAT;

	localparam logic [14:0] HI_BOUND = 15'h4308;
	localparam logic [15:0] FP_ZERO  = 16'h0000;
	localparam logic [15:0] QNAN_BIT = 16'h0200;
	localparam logic [15:0] C_A7     = 16'h0001;
	localparam logic [15:0] C_A5     = 16'h00F9;
	localparam logic [15:0] C_A3     = 16'h1138;
	localparam logic [15:0] C_A1     = 16'h1D03;
	localparam logic [15:0] C_B6     = 16'h0010;
	localparam logic [15:0] C_B4     = 16'h07C5;
	localparam logic [15:0] C_B2     = 16'h18A5;
	localparam logic [15:0] C_B0     = 16'h1D03;

	// Per-lane information that rides along the arithmetic pipeline.
	typedef struct packed {
		logic        lv;
		logic        byp;
		logic [15:0] byp_val;
		logic [15:0] x;
		logic [15:0] x2;
		logic [15:0] q;
	} side_t;

	// Significand with the hidden bit.
	function automatic logic [10:0] fp_mant(input logic [15:0] h);
		return {|h[14:10], h[9:0]};
	endfunction

	// Exponent of the significand LSB plus 24: zero for subnormals.
	function automatic logic [4:0] fp_ebias(input logic [15:0] h);
		return (h[14:10] == 5'd0) ? 5'd0 : h[14:10] - 5'd1;
	endfunction

endpackage

// ===== rtl/fthr_round.sv =====
`timescale 1ns / 1ps
// Two-stage rounding of a fixed-point magnitude to binary16, nearest-even.
module fthr_round (
	input  logic                      clk,
	input  logic                      en,
	input  logic [fthr_pkg::FIX_W-1:0] mag,
	input  logic                      sign,
	input  fthr_pkg::side_t           side_i,
	output logic [15:0]               res,
	output fthr_pkg::side_t           side_o
);
	import fthr_pkg::*;

	logic [SH_W-1:0]  lp_c;
	logic [FIX_W-1:0] mag_s1;
	logic [SH_W-1:0]  lp_s1;
	logic             sign_s1;
	side_t            side_s1;
	logic [SH_W-1:0]  sh;
	logic [FIX_W-1:0] shifted;
	logic [FIX_W-1:0] gmask;
	logic [10:0]      r;
	logic             guard;
	logic             sticky;
	logic             inc;
	logic [SH_W-1:0]  ex;
	logic [14:0]      bits;
	logic [15:0]      res_s2;
	side_t            side_s2;

	// Position of the leading one; zero input leaves it at 0.
	always_comb begin
		lp_c = '0;
		for (int i = 0; i < FIX_W; i++) begin
			if (mag[i]) begin
				lp_c = SH_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag;
			lp_s1   <= lp_c;
			sign_s1 <= sign;
			side_s1 <= side_i;
		end
	end

	// Keep 11 significant bits, but never go below the subnormal LSB.
	always_comb begin
		sh      = (lp_s1 > SH_W'(SUB_SH + 10)) ? lp_s1 - SH_W'(10) : SH_W'(SUB_SH);
		shifted = mag_s1 >> sh;
		r       = shifted[10:0];
		gmask   = FIX_W'(1) << (sh - SH_W'(1));
		guard   = |(mag_s1 & gmask);
		sticky  = |(mag_s1 & (gmask - FIX_W'(1)));
		inc     = guard & (sticky | r[0]);
		ex      = sh - SH_W'(SUB_SH);
		// A carry out of the significand rolls into the exponent field on its own.
		bits    = {ex[4:0], 10'b0} + {4'b0, r} + {14'b0, inc};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2  <= {sign_s1, bits};
			side_s2 <= side_s1;
		end
	end

	assign res    = res_s2;
	assign side_o = side_s2;

endmodule

// ===== rtl/fthr_fma.sv =====
`timescale 1ns / 1ps
// Pipelined binary16 fused multiply-add a*b+c with a single rounding.
module fthr_fma (
	input  logic            clk,
	input  logic            en,
	input  logic [15:0]     a,
	input  logic [15:0]     b,
	input  logic [15:0]     c,
	input  fthr_pkg::side_t side_i,
	output logic [15:0]     res,
	output fthr_pkg::side_t side_o
);
	import fthr_pkg::*;

	logic [21:0]      prod_s1;
	logic [SH_W-1:0]  psh_s1;
	logic             psign_s1;
	logic [15:0]      c_s1;
	side_t            side_s1;
	logic [FIX_W-1:0] mp;
	logic [FIX_W-1:0] mc;
	logic [FIX_W-1:0] sum_s2;
	logic             sign_s2;
	side_t            side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= {11'b0, fp_mant(a)} * {11'b0, fp_mant(b)};
			psh_s1   <= SH_W'(fp_ebias(a)) + SH_W'(fp_ebias(b));
			psign_s1 <= a[15] ^ b[15];
			c_s1     <= c;
			side_s1  <= side_i;
		end
	end

	// Addends are never negative when c is nonzero, so the sum is exact in fixed point.
	always_comb begin
		mp = FIX_W'(prod_s1) << psh_s1;
		mc = FIX_W'(fp_mant(c_s1)) << (SH_W'(fp_ebias(c_s1)) + SH_W'(SUB_SH));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= mp + mc;
			sign_s2 <= (c_s1[14:0] == 15'd0) ? psign_s1 : 1'b0;
			side_s2 <= side_s1;
		end
	end

	fthr_round u_rnd (
		.clk    (clk),
		.en     (en),
		.mag    (sum_s2),
		.sign   (sign_s2),
		.side_i (side_s2),
		.res    (res),
		.side_o (side_o)
	);

endmodule

// ===== rtl/fthr_div.sv =====
`timescale 1ns / 1ps
// Pipelined binary16 division, one quotient bit per stage, rounded nearest-even.
module fthr_div (
	input  logic            clk,
	input  logic            en,
	input  logic [15:0]     num,
	input  logic [15:0]     den,
	input  fthr_pkg::side_t side_i,
	output logic [15:0]     res,
	output fthr_pkg::side_t side_o
);
	import fthr_pkg::*;

	typedef struct packed {
		logic [11:0]          rem;
		logic [DIV_STEPS-1:0] quo;
		logic [10:0]          dv;
		logic [SH_W-1:0]      t;
		logic                 sign;
		side_t                side;
	} div_st_t;

	function automatic div_st_t div_step(input div_st_t s);
		div_st_t     o;
		logic        ge;
		logic [11:0] rn;
		o  = s;
		ge = s.rem >= {1'b0, s.dv};
		rn = ge ? s.rem - {1'b0, s.dv} : s.rem;
		o.rem = {rn[10:0], 1'b0};
		o.quo = {s.quo[DIV_STEPS-2:0], ge};
		return o;
	endfunction

	logic [10:0]      mn;
	logic [3:0]       lz;
	div_st_t          norm_c;
	div_st_t          iter_q [0:DIV_STEPS];
	logic [FIX_W-1:0] mag_s16;
	logic             sign_s16;
	side_t            side_s16;

	// Normalize the numerator so a nonzero quotient has its leading one in the top two bits.
	always_comb begin
		mn = fp_mant(num);
		lz = '0;
		for (int i = 0; i < 11; i++) begin
			if (mn[i]) begin
				lz = 4'(10 - i);
			end
		end
		norm_c.rem  = {1'b0, mn << lz};
		norm_c.quo  = '0;
		norm_c.dv   = fp_mant(den);
		norm_c.t    = SH_W'(7'(fp_ebias(num)) + 7'd35 - 7'(lz) - 7'(fp_ebias(den)));
		norm_c.sign = num[15] ^ den[15];
		norm_c.side = side_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			iter_q[0] <= norm_c;
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				iter_q[k+1] <= div_step(iter_q[k]);
			end
		end
	end

	// The remainder folds into the LSB as sticky; it lies well below the guard position.
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s16  <= (FIX_W'(iter_q[DIV_STEPS].quo) << iter_q[DIV_STEPS].t)
			            | FIX_W'(iter_q[DIV_STEPS].rem != 12'd0);
			sign_s16 <= iter_q[DIV_STEPS].sign;
			side_s16 <= iter_q[DIV_STEPS].side;
		end
	end

	fthr_round u_rnd (
		.clk    (clk),
		.en     (en),
		.mag    (mag_s16),
		.sign   (sign_s16),
		.side_i (side_s16),
		.res    (res),
		.side_o (side_o)
	);

endmodule

// ===== rtl/fthr_lane.sv =====
`timescale 1ns / 1ps
// One tanh lane: clamp, square, numerator and denominator polynomials, and the quotient.
module fthr_lane (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] x,
	input  logic        lv,
	output logic [15:0] res,
	output logic        lv_o
);
	import fthr_pkg::*;

	logic        nan;
	logic [15:0] xc;
	side_t       sd0, sd1, sd1x, sd2, sd3, sd4, sd4x, sd5, sd6;
	logic [15:0] sq, p1, p2, p3, p4, q1, q2, q3, quo;

	always_comb begin
		nan = (&x[14:10]) & (|x[9:0]);
		xc  = (x[14:0] > HI_BOUND) ? {x[15], HI_BOUND} : x;
		sd0.lv      = lv;
		sd0.byp     = !lv || nan;
		sd0.byp_val = (lv && nan) ? (x | QNAN_BIT) : x;
		sd0.x       = xc;
		sd0.x2      = '0;
		sd0.q       = '0;
	end

	fthr_fma u_sq (.clk(clk), .en(en), .a(xc), .b(xc), .c(FP_ZERO), .side_i(sd0),
		.res(sq), .side_o(sd1));

	always_comb begin
		sd1x    = sd1;
		sd1x.x2 = sq;
	end

	fthr_fma u_p1 (.clk(clk), .en(en), .a(C_A7), .b(sd1x.x2), .c(C_A5), .side_i(sd1x),
		.res(p1), .side_o(sd2));
	fthr_fma u_q1 (.clk(clk), .en(en), .a(C_B6), .b(sd1x.x2), .c(C_B4), .side_i(sd1x),
		.res(q1), .side_o());
	fthr_fma u_p2 (.clk(clk), .en(en), .a(p1), .b(sd2.x2), .c(C_A3), .side_i(sd2),
		.res(p2), .side_o(sd3));
	fthr_fma u_q2 (.clk(clk), .en(en), .a(q1), .b(sd2.x2), .c(C_B2), .side_i(sd2),
		.res(q2), .side_o());
	fthr_fma u_p3 (.clk(clk), .en(en), .a(p2), .b(sd3.x2), .c(C_A1), .side_i(sd3),
		.res(p3), .side_o(sd4));
	fthr_fma u_q3 (.clk(clk), .en(en), .a(q2), .b(sd3.x2), .c(C_B0), .side_i(sd3),
		.res(q3), .side_o());

	always_comb begin
		sd4x   = sd4;
		sd4x.q = q3;
	end

	fthr_fma u_p4 (.clk(clk), .en(en), .a(p3), .b(sd4x.x), .c(FP_ZERO), .side_i(sd4x),
		.res(p4), .side_o(sd5));

	fthr_div u_div (.clk(clk), .en(en), .num(p4), .den(sd5.q), .side_i(sd5),
		.res(quo), .side_o(sd6));

	assign res  = sd6.byp ? sd6.byp_val : quo;
	assign lv_o = sd6.lv;

endmodule

// ===== rtl/fp16_tanh_rational_approx.sv =====
`timescale 1ns / 1ps
// Top level of the four-lane half-precision tanh unit.
// Each beat carries four binary16 operands and a lane-valid mask; every lane runs its own
// fully pipelined datapath (square, two polynomial chains of fused multiply-adds, a
// bit-per-stage divider), so one beat is accepted every cycle while the pipeline advances,
// and each result passes through the multiply-add chain and then the divider. The whole
// pipeline advances whenever the output register is empty or being read. Lanes whose mask
// bit is clear, and NaN operands, come back unchanged (NaN made quiet); the mask is
// returned with the results.
module fp16_tanh_rational_approx (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// value_lane0 [15:0], value_lane1 [31:16], value_lane2 [47:32], value_lane3 [63:48],
	// lane_valid [67:64], zero fill [71:68]
	input  logic [fthr_pkg::TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// result_lane0 [15:0], result_lane1 [31:16], result_lane2 [47:32], result_lane3 [63:48],
	// result_valid [67:64], zero fill [71:68]
	output logic [fthr_pkg::TDATA_W-1:0] m_tdata
);
	import fthr_pkg::*;

	logic                adv;
	logic [LANE_LAT-1:0] vld_q;
	logic [15:0]         res_l [LANES];
	logic [LANES-1:0]    lv_l;

	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign m_tvalid = vld_q[LANE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LANE_LAT-2:0], s_tvalid};
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		fthr_lane u_lane (
			.clk  (clk),
			.en   (adv),
			.x    (s_tdata[g*FP_W +: FP_W]),
			.lv   (s_tdata[LANES*FP_W + g]),
			.res  (res_l[g]),
			.lv_o (lv_l[g])
		);
	end

	// Merge the lane results and the returned mask into one beat.
	always_comb begin
		m_tdata = '0;
		for (int g = 0; g < LANES; g++) begin
			m_tdata[g*FP_W +: FP_W] = res_l[g];
		end
		m_tdata[LANES*FP_W +: LANES] = lv_l;
	end

endmodule

// ===== dv/fp16_tanh_rational_approx_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the four-lane half-precision tanh unit.
module fp16_tanh_rational_approx_tb;
	import fthr_pkg::*;

	localparam int END_WAIT = 3 * LANE_LAT;

	typedef struct {
		logic [63:0] lanes;
		logic [3:0]  mask;
		bit          fixed;
		logic [63:0] want;
	} stim_row_t;

	typedef struct {
		logic [63:0] lanes;
		logic [3:0]  mask;
	} tanh_beat_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [TDATA_W-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [TDATA_W-1:0]  m_tdata;

	tanh_beat_t tanh_expected_q[$];
	int         err_cnt;
	bit         hold_off_req;
	bit         no_gaps;

	fp16_tanh_rational_approx u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// ---- binary16 arithmetic, exact then rounded once to nearest-even ----
	function automatic int bit_len(input logic [63:0] v);
		int n;
		n = 0;
		for (int i = 0; i < 64; i++)
			if (v[i]) n = i + 1;
		return n;
	endfunction

	function automatic void split16(input logic [15:0] h, output logic s,
			output logic [63:0] m, output int e);
		s = h[15];
		if (h[14:10] == 5'd0) begin
			m = {54'd0, h[9:0]};
			e = -24;
		end else begin
			m = {53'd0, 1'b1, h[9:0]};
			e = int'(h[14:10]) - 25;
		end
	endfunction

	function automatic logic [15:0] round_h(input logic s, input logic [63:0] mag, input int ex);
		int          q;
		int          sh;
		logic [63:0] r;
		logic [63:0] rem;
		logic [63:0] half;
		q = ex + bit_len(mag) - 11;
		if (q < -24) q = -24;
		sh = q - ex;
		if (sh <= 0) begin
			r = mag << (-sh);
		end else if (sh >= 63) begin
			r = 0;
		end else begin
			rem  = mag & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			r    = mag >> sh;
			if (rem > half || (rem == half && r[0])) r = r + 1;
		end
		if (r >= 64'd2048) begin
			r = r >> 1;
			q++;
		end
		if (r < 64'd1024) return {s, r[14:0]};
		if (q + 25 >= 31) return {s, 15'h7C00};
		return {s, 5'(q + 25), r[9:0]};
	endfunction

	function automatic logic [63:0] shift_sticky(input logic [63:0] m, input int d);
		if (d <= 0) return m;
		if (d >= 62) return 64'd1;
		return (m >> d) | {63'd0, |(m & ((64'd1 << d) - 64'd1))};
	endfunction

	function automatic logic [15:0] fp_mul(input logic [15:0] a, input logic [15:0] b);
		logic sa, sb;
		logic [63:0] ma, mb;
		int ea, eb;
		split16(a, sa, ma, ea);
		split16(b, sb, mb, eb);
		if (ma == 0 || mb == 0) return {sa ^ sb, 15'd0};
		return round_h(sa ^ sb, ma * mb, ea + eb);
	endfunction

	function automatic logic [15:0] fp_fma(input logic [15:0] a, input logic [15:0] b,
			input logic [15:0] c);
		logic sa, sb, sc, sp;
		logic [63:0] ma, mb, mc, mp;
		int ea, eb, ec, ep, n;
		split16(a, sa, ma, ea);
		split16(b, sb, mb, eb);
		split16(c, sc, mc, ec);
		sp = sa ^ sb;
		mp = ma * mb;
		ep = ea + eb;
		if (mp == 0 && mc == 0) return {sp & sc, 15'd0};
		if (mp == 0) return c;
		if (mc == 0) return round_h(sp, mp, ep);
		n  = 61 - bit_len(mp);
		ep = ep - n;
		mp = mp << n;
		n  = 61 - bit_len(mc);
		ec = ec - n;
		mc = mc << n;
		if (ep >= ec) begin
			mc = shift_sticky(mc, ep - ec);
			ec = ep;
		end else begin
			mp = shift_sticky(mp, ec - ep);
			ep = ec;
		end
		if (sp == sc) return round_h(sp, mp + mc, ep);
		if (mp == mc) return 16'h0000;
		if (mp > mc) return round_h(sp, mp - mc, ep);
		return round_h(sc, mc - mp, ep);
	endfunction

	function automatic logic [15:0] fp_div(input logic [15:0] a, input logic [15:0] b);
		logic sa, sb;
		logic [63:0] ma, mb, num, quo;
		int ea, eb;
		split16(a, sa, ma, ea);
		split16(b, sb, mb, eb);
		if (ma == 0 || mb == 0) return {sa ^ sb, 15'd0};
		num = ma << 50;
		quo = num / mb;
		if (num % mb != 0) quo[0] = 1'b1;
		return round_h(sa ^ sb, quo, ea - 50 - eb);
	endfunction

	function automatic logic [15:0] tanh_h(input logic [15:0] x_in);
		logic [15:0] x, x2, p, q;
		x = x_in;
		if (x[14:10] == 5'h1F && x[9:0] != 0) return x | QNAN_BIT;
		if (x[14:0] > HI_BOUND) x = {x[15], HI_BOUND};
		x2 = fp_mul(x, x);
		p = fp_fma(C_A7, x2, C_A5);
		p = fp_fma(p, x2, C_A3);
		p = fp_fma(p, x2, C_A1);
		p = fp_mul(p, x);
		q = fp_fma(C_B6, x2, C_B4);
		q = fp_fma(q, x2, C_B2);
		q = fp_fma(q, x2, C_B0);
		return fp_div(p, q);
	endfunction

	function automatic logic [63:0] tanh_lanes(input logic [63:0] v, input logic [3:0] mask);
		logic [63:0] r;
		for (int i = 0; i < LANES; i++)
			r[i*16 +: 16] = mask[i] ? tanh_h(v[i*16 +: 16]) : v[i*16 +: 16];
		return r;
	endfunction

	// ---- stimulus ----
	function automatic logic [15:0] rand_operand();
		logic [15:0] v;
		v = 16'($urandom);
		case ($urandom_range(0, 9))
			0: v = {v[15], 15'h4300 + 15'($urandom_range(0, 16))};
			1: v = {v[15], 5'h1F, v[9:0]};
			2: v = {v[15], 5'h00, v[9:0]};
			3: v = {v[15], 15'd0};
			4: v = {v[15], 5'($urandom_range(8, 17)), v[9:0]};
			default: ;
		endcase
		return v;
	endfunction

	task automatic send_beat(input logic [63:0] v, input logic [3:0] mask);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tdata  <= {4'd0, mask, v};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		tanh_expected_q.push_back('{lanes: v, mask: mask});
	endtask

	stim_row_t directed[] = '{
		'{64'h7BFF_4308_FC00_7C00, 4'hF, 1'b0, 64'h0},
		'{64'h8001_0001_C309_4309, 4'hF, 1'b0, 64'h0},
		'{64'h83FF_03FF_BC00_3C00, 4'hF, 1'b0, 64'h0},
		'{64'h8000_0000_FC01_7C01, 4'hF, 1'b1, 64'h8000_0000_FE01_7E01},
		'{64'hFFFF_7E00_FE00_7FFF, 4'hF, 1'b1, 64'hFFFF_7E00_FE00_7FFF},
		'{64'hFFFF_0000_7C01_C308, 4'h0, 1'b1, 64'hFFFF_0000_7C01_C308},
		'{64'h3555_2AAA_FBFF_0400, 4'h5, 1'b0, 64'h0},
		'{64'hC000_4000_B800_3800, 4'hA, 1'b0, 64'h0},
		'{64'h4307_C307_2000_A000, 4'h9, 1'b0, 64'h0},
		'{64'h0400_8400_3E00_BE00, 4'h6, 1'b0, 64'h0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 4'hE, 1'b0, 64'h0},
		'{64'h0000_0000_0000_0000, 4'h1, 1'b1, 64'h0}
	};

	initial begin
		logic [63:0] v;
		logic [3:0]  mask;
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		err_cnt      = 0;
		hold_off_req = 1'b0;
		no_gaps      = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_beat(directed[i].lanes, directed[i].mask);
		for (int n = 0; n < 500; n++) begin
			no_gaps <= (n >= 200 && n < 260);
			if (n == 300) hold_off_req <= 1'b1;
			for (int i = 0; i < LANES; i++) v[i*16 +: 16] = rand_operand();
			mask = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF;
			send_beat(v, mask);
		end
		s_tvalid <= 1'b0;
		wait (tanh_expected_q.size() == 0);
		repeat (END_WAIT) @(posedge clk);
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: random stalls per beat, and one long hold-off to back up the pipeline.
	initial begin
		int w;
		bit held;
		m_tready = 1'b0;
		held     = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off_req && !held) begin
				m_tready <= 1'b0;
				repeat (4 * LANE_LAT) @(posedge clk);
				held = 1'b1;
			end
			w = no_gaps ? 0 : $urandom_range(0, 3);
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// Directed rows with a typed-in answer are looked up by beat order.
	int beat_idx = 0;
	always @(posedge clk) begin
		tanh_beat_t  exp_beat;
		logic [63:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (tanh_expected_q.size() == 0) begin
				$error("result beat with nothing expected: %h", m_tdata);
				err_cnt++;
			end else begin
				exp_beat = tanh_expected_q.pop_front();
				if (beat_idx < directed.size() && directed[beat_idx].fixed)
					want = directed[beat_idx].want;
				else
					want = tanh_lanes(exp_beat.lanes, exp_beat.mask);
				for (int i = 0; i < LANES; i++)
					if (m_tdata[i*16 +: 16] !== want[i*16 +: 16]) begin
						$error("result_lane%0d expected %h actual %h (input %h)", i,
							want[i*16 +: 16], m_tdata[i*16 +: 16], exp_beat.lanes[i*16 +: 16]);
						err_cnt++;
					end
				if (m_tdata[67:64] !== exp_beat.mask) begin
					$error("result_valid expected %h actual %h", exp_beat.mask, m_tdata[67:64]);
					err_cnt++;
				end
			end
			beat_idx++;
		end
	end

	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/fthr_pkg.sv
rtl/fthr_round.sv
rtl/fthr_fma.sv
rtl/fthr_div.sv
rtl/fthr_lane.sv
rtl/fp16_tanh_rational_approx.sv
dv/fp16_tanh_rational_approx_tb.sv
